@@ rtl/lrsc_pkg.sv @@
// Shared types, constants and helpers for the register slot cache.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package lrsc_pkg;

  // slot count and derived sizes
  localparam int NUM_SLOTS = 3;
  localparam int MAX_RES = NUM_SLOTS + 1;
  localparam int RES_IDX_W = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int CNT_W = $clog2(MAX_RES + 1);

  // operation codes
  localparam logic [3:0] MODE_READ = 4'd0;
  localparam logic [3:0] MODE_WRITE = 4'd1;
  localparam logic [3:0] MODE_LOCK = 4'd2;
  localparam logic [3:0] MODE_UNLOCK = 4'd3;
  localparam logic [3:0] MODE_FLUSH = 4'd4;
  localparam logic [3:0] MODE_GATE = 4'd5;
  localparam logic [3:0] MODE_BEGIN = 4'd6;
  localparam logic [3:0] MODE_END = 4'd7;
  localparam logic [3:0] MODE_SPILL = 4'd8;
  localparam logic [3:0] MODE_RELOAD = 4'd9;

  // result kinds
  localparam logic [1:0] KIND_SPILL = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // configuration register indexes
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_PERSIST = 1'b1;

  // instruction gate fields
  localparam logic [5:0] COP1_OPCODE = 6'd17;
  localparam logic [4:0] FMT_SINGLE = 5'd16;
  localparam logic [4:0] FMT_DOUBLE = 5'd17;
  localparam logic [5:0] FN_ARITH_MAX = 6'd7;
  localparam logic [5:0] FN_CMP_MIN = 6'h30;

  typedef struct packed {
    logic [3:0]  mode;
    logic [4:0]  reg_index;
    logic [3:0]  host_reg;
    logic [31:0] instr_word;
    logic        double_prec;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot_index;
    logic [4:0] mapped_reg;
    logic       prec;
    logic [3:0] result_reg;
    logic       cache_empty;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [3:0] base;
    logic       persist;
  } cfg_t;

  // all result words of one item, packed from index zero
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    out_word_t [MAX_RES-1:0]   words;
  } res_batch_t;

  function automatic out_word_t mk_word(input logic [1:0] kind, input logic [2:0] slot,
                                        input logic [4:0] mreg, input logic prec,
                                        input logic [3:0] rreg, input logic empty,
                                        input logic last);
    out_word_t w;
    w.kind = kind;
    w.slot_index = slot;
    w.mapped_reg = mreg;
    w.prec = prec;
    w.result_reg = rreg;
    w.cache_empty = empty;
    w.last = last;
    return w;
  endfunction

  // cop1 single or double op that understands cached slots
  function automatic logic is_aware(input logic [31:0] w);
    logic [4:0] fmt;
    logic [5:0] fn;
    fmt = w[25:21];
    fn = w[5:0];
    return (w[31:26] == COP1_OPCODE) && (fmt == FMT_SINGLE || fmt == FMT_DOUBLE) &&
           (fn <= FN_ARITH_MAX || fn >= FN_CMP_MIN);
  endfunction

endpackage

`default_nettype wire

@@ rtl/lrsc_slot_engine.sv @@
// Slot state and the single-pass update for one operation.
// Depends on lrsc_pkg; feeds a batch of result words to lrsc_result_queue.
`default_nettype none

module lrsc_slot_engine (
  input  wire                   clk,
  input  wire                   rst,
  input  lrsc_pkg::cfg_t        cfg,
  input  lrsc_pkg::in_word_t    item,
  input  wire                   item_go,
  output lrsc_pkg::res_batch_t  batch
);

  localparam int N = lrsc_pkg::NUM_SLOTS;

  logic [N-1:0] slot_valid, slot_valid_next;
  logic [N-1:0] slot_dirty, slot_dirty_next;
  logic [N-1:0] slot_locked, slot_locked_next;
  logic [4:0]   slot_reg [N];
  logic [4:0]   slot_reg_next [N];
  logic [31:0]  slot_stamp [N];
  logic [31:0]  slot_stamp_next [N];
  logic [31:0]  use_clock, use_clock_next;
  logic         double_mode, double_mode_next;

  // operation decode, slot search and result packing
  always_comb begin
    logic [lrsc_pkg::CNT_W-1:0] cnt;
    logic       hit_any, free_any, vic_any, err, need_flush;
    logic [2:0] hit_s, free_s, vic_s, sel_s;
    logic [31:0] vic_min, clk_inc;
    logic [3:0] lock_off, done_rreg;

    slot_valid_next = slot_valid;
    slot_dirty_next = slot_dirty;
    slot_locked_next = slot_locked;
    slot_reg_next = slot_reg;
    slot_stamp_next = slot_stamp;
    use_clock_next = use_clock;
    double_mode_next = double_mode;
    batch = '0;
    cnt = '0;
    err = 1'b0;
    need_flush = 1'b0;
    done_rreg = '0;
    sel_s = '0;
    clk_inc = use_clock + 32'd1;
    lock_off = item.host_reg - cfg.base;

    // hit, lowest free slot, oldest unlocked slot
    hit_any = 1'b0;
    hit_s = '0;
    free_any = 1'b0;
    free_s = '0;
    vic_any = 1'b0;
    vic_s = '0;
    vic_min = '0;
    for (int i = 0; i < N; i++) begin
      if (!hit_any && slot_valid[i] && slot_reg[i] == item.reg_index) begin
        hit_any = 1'b1;
        hit_s = 3'(i);
      end
      if (!free_any && !slot_valid[i]) begin
        free_any = 1'b1;
        free_s = 3'(i);
      end
      if (!slot_locked[i] && (!vic_any || slot_stamp[i] < vic_min)) begin
        vic_any = 1'b1;
        vic_s = 3'(i);
        vic_min = slot_stamp[i];
      end
    end

    case (item.mode)
      lrsc_pkg::MODE_READ, lrsc_pkg::MODE_WRITE: begin
        if (hit_any || free_any || vic_any) begin
          if (hit_any) begin
            sel_s = hit_s;
          end else if (free_any) begin
            sel_s = free_s;
          end else begin
            sel_s = vic_s;
          end
          for (int i = 0; i < N; i++) begin
            if (sel_s == 3'(i)) begin
              if (!hit_any) begin
                // victim spill when no free slot was left
                if (!free_any) begin
                  if (slot_dirty[i]) begin
                    batch.words[cnt[lrsc_pkg::RES_IDX_W-1:0]] = lrsc_pkg::mk_word(
                        lrsc_pkg::KIND_SPILL, 3'(i), slot_reg[i], double_mode, '0, 1'b0, 1'b0);
                    cnt = cnt + 1'b1;
                  end
                  slot_locked_next[i] = 1'b0;
                end
                slot_valid_next[i] = 1'b1;
                slot_reg_next[i] = item.reg_index;
                slot_dirty_next[i] = 1'b0;
                if (item.mode == lrsc_pkg::MODE_READ) begin
                  batch.words[cnt[lrsc_pkg::RES_IDX_W-1:0]] = lrsc_pkg::mk_word(
                      lrsc_pkg::KIND_FILL, 3'(i), item.reg_index, double_mode, '0, 1'b0, 1'b0);
                  cnt = cnt + 1'b1;
                end
              end
              if (item.mode == lrsc_pkg::MODE_WRITE) begin
                slot_dirty_next[i] = 1'b1;
              end
              slot_stamp_next[i] = clk_inc;
            end
          end
          use_clock_next = clk_inc;
          done_rreg = cfg.base + {1'b0, sel_s};
        end else begin
          err = 1'b1;
        end
      end
      lrsc_pkg::MODE_LOCK: begin
        for (int i = 0; i < N; i++) begin
          if (item.host_reg >= cfg.base && lock_off == 4'(i)) begin
            slot_locked_next[i] = 1'b1;
          end
        end
      end
      lrsc_pkg::MODE_UNLOCK: begin
        slot_locked_next = '0;
      end
      lrsc_pkg::MODE_FLUSH: begin
        need_flush = 1'b1;
      end
      lrsc_pkg::MODE_GATE: begin
        need_flush = !lrsc_pkg::is_aware(item.instr_word);
      end
      lrsc_pkg::MODE_BEGIN: begin
        if (cfg.persist) begin
          need_flush = (item.double_prec != double_mode);
        end else if (|slot_valid) begin
          err = 1'b1;
        end else begin
          // fresh start: every slot and the use clock back to zero
          for (int i = 0; i < N; i++) begin
            slot_reg_next[i] = '0;
            slot_stamp_next[i] = '0;
          end
          slot_dirty_next = '0;
          use_clock_next = '0;
        end
      end
      lrsc_pkg::MODE_END: begin
        need_flush = !cfg.persist;
      end
      lrsc_pkg::MODE_SPILL: begin
        for (int i = 0; i < N; i++) begin
          if (slot_valid[i] && slot_dirty[i]) begin
            batch.words[cnt[lrsc_pkg::RES_IDX_W-1:0]] = lrsc_pkg::mk_word(
                lrsc_pkg::KIND_SPILL, 3'(i), slot_reg[i], double_mode, '0, 1'b0, 1'b0);
            cnt = cnt + 1'b1;
          end
        end
      end
      lrsc_pkg::MODE_RELOAD: begin
        for (int i = 0; i < N; i++) begin
          if (slot_valid[i]) begin
            batch.words[cnt[lrsc_pkg::RES_IDX_W-1:0]] = lrsc_pkg::mk_word(
                lrsc_pkg::KIND_FILL, 3'(i), slot_reg[i], double_mode, '0, 1'b0, 1'b0);
            cnt = cnt + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // flush: spill dirty slots at the old precision, then empty every slot
    if (need_flush) begin
      for (int i = 0; i < N; i++) begin
        if (slot_valid[i] && slot_dirty[i]) begin
          batch.words[cnt[lrsc_pkg::RES_IDX_W-1:0]] = lrsc_pkg::mk_word(
              lrsc_pkg::KIND_SPILL, 3'(i), slot_reg[i], double_mode, '0, 1'b0, 1'b0);
          cnt = cnt + 1'b1;
        end
        slot_reg_next[i] = '0;
      end
      slot_valid_next = '0;
      slot_dirty_next = '0;
      slot_locked_next = '0;
    end

    // begin sets the precision and drops all locks
    if (item.mode == lrsc_pkg::MODE_BEGIN && !err) begin
      double_mode_next = item.double_prec;
      slot_locked_next = '0;
    end

    // closing word
    if (err) begin
      batch.words[cnt[lrsc_pkg::RES_IDX_W-1:0]] = lrsc_pkg::mk_word(
          lrsc_pkg::KIND_ERROR, '0, '0, double_mode, '0, 1'b0, 1'b1);
      slot_valid_next = slot_valid;
      slot_dirty_next = slot_dirty;
      slot_locked_next = slot_locked;
      slot_reg_next = slot_reg;
      slot_stamp_next = slot_stamp;
      use_clock_next = use_clock;
      double_mode_next = double_mode;
    end else begin
      batch.words[cnt[lrsc_pkg::RES_IDX_W-1:0]] = lrsc_pkg::mk_word(
          lrsc_pkg::KIND_DONE, '0, '0, double_mode_next, done_rreg,
          ~|slot_valid_next, 1'b1);
    end
    batch.count = cnt + 1'b1;
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_dirty <= '0;
      slot_locked <= '0;
      use_clock <= '0;
      double_mode <= 1'b0;
      for (int i = 0; i < N; i++) begin
        slot_reg[i] <= '0;
        slot_stamp[i] <= '0;
      end
    end else if (item_go) begin
      slot_valid <= slot_valid_next;
      slot_dirty <= slot_dirty_next;
      slot_locked <= slot_locked_next;
      use_clock <= use_clock_next;
      double_mode <= double_mode_next;
      slot_reg <= slot_reg_next;
      slot_stamp <= slot_stamp_next;
    end
  end

`ifndef SYNTHESIS
  // state only moves when an operation is taken
  assert property (@(posedge clk) disable iff (rst)
    !item_go |=> $stable(use_clock) && $stable(slot_valid) && $stable(slot_locked))
    else $error("slot state changed without an operation");
`endif

endmodule

`default_nettype wire

@@ rtl/lrsc_result_queue.sv @@
// Result queue: holds the words of one operation and sends them one a cycle while out_ready is high.
// Depends on lrsc_pkg; loaded from lrsc_slot_engine.
`default_nettype none

module lrsc_result_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  lrsc_pkg::res_batch_t  batch,
  input  wire                   load,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire                   out_ready,
  output lrsc_pkg::out_word_t   out_data
);

  localparam int M = lrsc_pkg::MAX_RES;

  lrsc_pkg::out_word_t        words [M];
  logic [lrsc_pkg::CNT_W-1:0] q_cnt;
  logic                       pop;

  assign out_valid = (q_cnt != '0);
  assign out_data = words[0];
  assign pop = out_valid && out_ready;
  // room once the queue is empty or its last word leaves now
  assign can_load = (q_cnt == '0) || (q_cnt == lrsc_pkg::CNT_W'(1) && pop);

  // word count
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else if (load) begin
      q_cnt <= batch.count;
    end else if (pop) begin
      q_cnt <= q_cnt - 1'b1;
    end
  end

  // word storage, head at entry zero
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < M; i++) begin
        words[i] <= batch.words[i];
      end
    end else if (pop) begin
      for (int i = 0; i < M - 1; i++) begin
        words[i] <= words[i + 1];
      end
    end
  end

`ifndef SYNTHESIS
  // a new batch never overwrites words still waiting
  assert property (@(posedge clk) disable iff (rst)
    load |-> (q_cnt == '0 || (q_cnt == lrsc_pkg::CNT_W'(1) && pop)))
    else $error("result batch loaded over pending words");

  // the last flag marks exactly the final queued word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (words[0].last == (q_cnt == lrsc_pkg::CNT_W'(1))))
    else $error("last flag out of step with queue count");
`endif

endmodule

`default_nettype wire

@@ rtl/lru_register_slot_cache_top.sv @@
// Path: an input word is taken into the input register; its result words are
// loaded into the result queue once that has room, and offered from there.
// Throughput: one input word per cycle while out_ready holds high and each item
// yields one word; more words hold the queue and input until the last is taken.
// Reset (synchronous): slots empty and unlocked, stamps and use clock zero,
// single precision, slot base 0, persistent mode on.
// Top level of the register slot cache; depends on lrsc_pkg and its submodules.
`default_nettype none

module lru_register_slot_cache_top (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lrsc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lrsc_pkg::out_word_t  out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_index,
  input  wire [3:0]            cfg_data
);

  lrsc_pkg::cfg_t        cfg;
  lrsc_pkg::in_word_t    item;
  logic                  item_valid;
  logic                  item_go;
  logic                  q_can_load;
  lrsc_pkg::res_batch_t  batch;

  assign item_go = item_valid && q_can_load;
  assign in_ready = !item_valid || q_can_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base <= '0;
      cfg.persist <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        lrsc_pkg::CFG_BASE:    cfg.base <= cfg_data;
        lrsc_pkg::CFG_PERSIST: cfg.persist <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  lrsc_slot_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .item_go (item_go),
    .batch   (batch)
  );

  lrsc_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .batch     (batch),
    .load      (item_go),
    .can_load  (q_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
